FILE: hw/rtl/strmq_pkg.sv
// Shared constants, codes and helper functions of the sparse-table range-minimum engine.
package strmq_pkg;

    // Table geometry.
    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int VALUE_WIDTH  = 32;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int LVL_W        = $clog2(LEVELS);
    localparam int ADDR_W       = LVL_W + IDX_W;
    localparam int DEPTH        = LEVELS * MAX_ELEMENTS;

    // Port widths.
    localparam int CMD_W    = 2;
    localparam int POS_W    = 11;
    localparam int STATUS_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Smaller of two signed values.
    function automatic logic [VALUE_WIDTH-1:0] min_val(input logic [VALUE_WIDTH-1:0] a,
                                                       input logic [VALUE_WIDTH-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    // Floor of log2 of a nonzero length, saturated at the top level of the table.
    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) begin
                r = (i > LEVELS - 1) ? LVL_W'(LEVELS - 1) : LVL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/strmq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module strmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: hw/rtl/sparse_table_range_minimum.sv
// Top level of the sparse-table range-minimum engine.
//
// The input channel carries one command per transaction: load appends a signed
// value, query returns the minimum between two 1-based positions given in
// either order, clear empties the table. Every transaction gives exactly one
// result transaction with a minimum and a status.
// A load writes level 0 and then walks up the levels, one RAM read and one
// write per level, each level using the entry just written below it. A query
// takes two reads of the single RAM read port, one per window, and keeps the
// smaller value. Clear, unknown commands, flagged queries, loads into a full
// table and a load into an empty table go straight to the done state.
// One transaction is worked on at a time; the next one is accepted once the
// result has moved to the output register, which can still be waiting.
// Reset empties the table and the output register; the table RAM needs no
// clearing pass, as entries are only read after a load since the last clear
// has written them. When the receiver stalls, the result holds steady and a
// finished transaction waits until the output register frees up.
module sparse_table_range_minimum (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [strmq_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [strmq_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic [strmq_pkg::POS_W-1:0]        i_pos_a,
    input  logic [strmq_pkg::POS_W-1:0]        i_pos_b,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [strmq_pkg::VALUE_WIDTH-1:0] o_minimum,
    output logic [strmq_pkg::STATUS_W-1:0]     o_status
);

    localparam int VW    = strmq_pkg::VALUE_WIDTH;
    localparam int IDX_W = strmq_pkg::IDX_W;
    localparam int CNT_W = strmq_pkg::CNT_W;
    localparam int LVL_W = strmq_pkg::LVL_W;
    localparam int ADW   = strmq_pkg::ADDR_W;
    localparam int SW    = strmq_pkg::STATUS_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_QRD1 = 3'd2;
    localparam logic [2:0] S_QRD2 = 3'd3;
    localparam logic [2:0] S_QCMP = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_p, n_p;
    logic [LVL_W-1:0] r_k, n_k;
    logic [VW-1:0]    r_carry, n_carry;
    logic [CNT_W-1:0] r_l, n_l;
    logic [CNT_W-1:0] r_r, n_r;
    logic [ADW-1:0]   r_addr2, n_addr2;
    logic [VW-1:0]    r_first, n_first;
    logic [VW-1:0]    r_res_min, n_res_min;
    logic [SW-1:0]    r_res_status, n_res_status;
    logic             r_out_valid, n_out_valid;
    logic [VW-1:0]    r_out_min, n_out_min;
    logic [SW-1:0]    r_out_status, n_out_status;

    logic             ram_we;
    logic [ADW-1:0]   ram_waddr;
    logic [VW-1:0]    ram_wdata;
    logic             ram_re;
    logic [ADW-1:0]   ram_raddr;
    logic [VW-1:0]    ram_rdata;

    logic             in_acc;
    logic             out_free;
    logic [CNT_W-1:0] pos_a;
    logic [CNT_W-1:0] pos_b;
    logic [CNT_W-1:0] q_lo;
    logic [CNT_W-1:0] q_hi;
    logic [CNT_W-1:0] p1;
    logic [CNT_W-1:0] span_cur;
    logic [CNT_W-1:0] span_next;
    logic [CNT_W-1:0] s_cur;
    logic [CNT_W-1:0] s_next;
    logic [VW-1:0]    lvl_min;
    logic [CNT_W-1:0] q_len;
    logic [LVL_W-1:0] q_k;
    logic [CNT_W-1:0] q_span;
    logic [CNT_W-1:0] q_left;
    logic [CNT_W-1:0] q_right;

    // Table storage: level in the upper address bits, position in the lower.
    strmq_ram #(
        .WIDTH (VW),
        .DEPTH (strmq_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshakes.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Query endpoints in ascending order.
    assign pos_a = CNT_W'(i_pos_a);
    assign pos_b = CNT_W'(i_pos_b);
    assign q_lo  = (pos_a < pos_b) ? pos_a : pos_b;
    assign q_hi  = (pos_a < pos_b) ? pos_b : pos_a;

    // Window arithmetic for the level walk of a load.
    assign p1        = CNT_W'(r_p) + CNT_W'(1);
    assign span_cur  = CNT_W'(1) << r_k;
    assign span_next = CNT_W'(1) << (r_k + LVL_W'(1));
    assign s_cur     = p1 - span_cur;
    assign s_next    = p1 - span_next;
    assign lvl_min   = strmq_pkg::min_val(ram_rdata, r_carry);

    // Level and the two overlapping windows of a query.
    assign q_len   = r_r - r_l + CNT_W'(1);
    assign q_k     = strmq_pkg::floor_log2(q_len);
    assign q_span  = CNT_W'(1) << q_k;
    assign q_left  = r_l - CNT_W'(1);
    assign q_right = r_r - q_span;

    // Sequencer and datapath next state.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_p          = r_p;
        n_k          = r_k;
        n_carry      = r_carry;
        n_l          = r_l;
        n_r          = r_r;
        n_addr2      = r_addr2;
        n_first      = r_first;
        n_res_min    = r_res_min;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_min    = r_out_min;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        // The receiver took the waiting result.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_min    = '0;
                    n_res_status = strmq_pkg::ST_OK;
                    n_state      = S_DONE;
                    case (i_cmd)
                        strmq_pkg::CMD_LOAD: begin
                            if (r_count == CNT_W'(strmq_pkg::MAX_ELEMENTS)) begin
                                n_res_status = strmq_pkg::ST_FULL;
                            end else begin
                                // Level 0 holds the value; start the walk upward.
                                ram_we    = 1'b1;
                                ram_waddr = {LVL_W'(0), r_count[IDX_W-1:0]};
                                ram_wdata = i_value;
                                n_carry   = i_value;
                                n_p       = r_count[IDX_W-1:0];
                                n_k       = LVL_W'(1);
                                n_count   = r_count + CNT_W'(1);
                                if (r_count != '0) begin
                                    ram_re    = 1'b1;
                                    ram_raddr = {LVL_W'(0),
                                                 r_count[IDX_W-1:0] - IDX_W'(1)};
                                    n_state   = S_LOAD;
                                end
                            end
                        end
                        strmq_pkg::CMD_QUERY: begin
                            if (q_lo == '0 || q_hi > r_count) begin
                                n_res_status = strmq_pkg::ST_RANGE;
                            end else begin
                                n_l     = q_lo;
                                n_r     = q_hi;
                                n_state = S_QRD1;
                            end
                        end
                        strmq_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                // Combine the older half read from the RAM with the half just written.
                ram_we    = 1'b1;
                ram_waddr = {r_k, s_cur[IDX_W-1:0]};
                ram_wdata = lvl_min;
                n_carry   = lvl_min;
                if (r_k < LVL_W'(strmq_pkg::LEVELS - 1) && span_next <= p1) begin
                    ram_re    = 1'b1;
                    ram_raddr = {r_k, s_next[IDX_W-1:0]};
                    n_k       = r_k + LVL_W'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QRD1: begin
                ram_re    = 1'b1;
                ram_raddr = {q_k, q_left[IDX_W-1:0]};
                n_addr2   = {q_k, q_right[IDX_W-1:0]};
                n_state   = S_QRD2;
            end
            S_QRD2: begin
                ram_re    = 1'b1;
                ram_raddr = r_addr2;
                n_first   = ram_rdata;
                n_state   = S_QCMP;
            end
            S_QCMP: begin
                n_res_min = strmq_pkg::min_val(r_first, ram_rdata);
                n_state   = S_DONE;
            end
            S_DONE: begin
                // Move the result to the output register once it is free.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_min    = r_res_min;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p          <= n_p;
        r_k          <= n_k;
        r_carry      <= n_carry;
        r_l          <= n_l;
        r_r          <= n_r;
        r_addr2      <= n_addr2;
        r_first      <= n_first;
        r_res_min    <= n_res_min;
        r_res_status <= n_res_status;
        r_out_min    <= n_out_min;
        r_out_status <= n_out_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_minimum   = r_out_min;
    assign o_status    = r_out_status;

endmodule

FILE: hw/rtl/strmq_checker.sv
// Port-level checker for the sparse-table range-minimum engine and its bind.
module strmq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [strmq_pkg::VALUE_WIDTH-1:0]   o_minimum,
    input logic [strmq_pkg::STATUS_W-1:0]      o_status
);

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == strmq_pkg::ST_OK || o_status == strmq_pkg::ST_RANGE
                         || o_status == strmq_pkg::ST_FULL))
        else $error("undefined status code on output");

    // A flagged transaction carries a zero minimum.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != strmq_pkg::ST_OK) |-> (o_minimum == '0))
        else $error("flagged result with nonzero minimum");

    // A transaction accepted now cannot produce its result in the next cycle.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared one cycle after acceptance");

    // The output register is empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_minimum)
                                          && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind sparse_table_range_minimum strmq_checker u_strmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_minimum   (o_minimum),
    .o_status    (o_status)
);

FILE: dv/sparse_table_range_minimum_tb.sv
// Self-checking testbench for the sparse-table range-minimum engine.
`timescale 1ns / 100ps

module sparse_table_range_minimum_tb;

    localparam int CMD_W        = strmq_pkg::CMD_W;
    localparam int VALUE_WIDTH  = strmq_pkg::VALUE_WIDTH;
    localparam int POS_W        = strmq_pkg::POS_W;
    localparam int STATUS_W     = strmq_pkg::STATUS_W;
    localparam int LEVELS       = strmq_pkg::LEVELS;
    localparam int MAX_ELEMENTS = strmq_pkg::MAX_ELEMENTS;

    // Command code that the block must treat as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam int ITEM_TARGET = 1750;
    localparam int QUIET_ITEMS = 150;
    localparam int FULL_FILL_AFTER = 400;

    typedef struct {
        logic signed [VALUE_WIDTH-1:0] minimum;
        logic [STATUS_W-1:0]           status;
    } t_answer;

    typedef struct {
        logic [CMD_W-1:0]              cmd;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [POS_W-1:0]              pos_a;
        logic [POS_W-1:0]              pos_b;
        bit                            typed;
        logic signed [VALUE_WIDTH-1:0] want_min;
        logic [STATUS_W-1:0]           want_status;
    } t_step;

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    logic [CMD_W-1:0]              i_cmd       = strmq_pkg::CMD_CLEAR;
    logic signed [VALUE_WIDTH-1:0] i_value     = '0;
    logic [POS_W-1:0]              i_pos_a     = '0;
    logic [POS_W-1:0]              i_pos_b     = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [VALUE_WIDTH-1:0] o_minimum;
    logic [STATUS_W-1:0]           o_status;

    // Shadow copy of the table and its fill level.
    logic signed [VALUE_WIDTH-1:0] level_mem [LEVELS][MAX_ELEMENTS];
    int unsigned                   elem_count = 0;

    t_answer pending_answers[$];
    t_step   directed_steps[$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    int      gap_level      = 0;
    int      stall_level    = 0;
    int      stall_left     = 0;
    bit      full_done      = 1'b0;

    sparse_table_range_minimum DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_pos_a     (i_pos_a),
        .i_pos_b     (i_pos_b),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_minimum   (o_minimum),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("sparse_table_range_minimum test failed");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Updates the shadow table for one transaction and works out its answer.
    task automatic predict_answer(input logic [CMD_W-1:0] cmd,
                                  input logic signed [VALUE_WIDTH-1:0] value,
                                  input logic [POS_W-1:0] pos_a,
                                  input logic [POS_W-1:0] pos_b,
                                  output t_answer ans);
        int unsigned                   p;
        int unsigned                   span;
        int unsigned                   lo;
        int unsigned                   hi;
        int unsigned                   len;
        int unsigned                   lvl;
        logic signed [VALUE_WIDTH-1:0] left;
        logic signed [VALUE_WIDTH-1:0] right;
        ans.minimum = '0;
        ans.status  = strmq_pkg::ST_OK;
        case (cmd)
            strmq_pkg::CMD_LOAD: begin
                if (elem_count >= MAX_ELEMENTS) begin
                    ans.status = strmq_pkg::ST_FULL;
                end else begin
                    p = elem_count;
                    level_mem[0][p] = value;
                    // Each level whose window now ends at the new element gets its minimum.
                    for (int k = 1; k < LEVELS; k++) begin
                        span = 1 << k;
                        if (span > p + 1) break;
                        left  = level_mem[k-1][p + 1 - span];
                        right = level_mem[k-1][p + 1 - span + span / 2];
                        level_mem[k][p + 1 - span] = (left < right) ? left : right;
                    end
                    elem_count = p + 1;
                end
            end
            strmq_pkg::CMD_QUERY: begin
                lo = (pos_a < pos_b) ? pos_a : pos_b;
                hi = (pos_a < pos_b) ? pos_b : pos_a;
                if (lo == 0 || hi > elem_count) begin
                    ans.status = strmq_pkg::ST_RANGE;
                end else begin
                    len = hi - lo + 1;
                    lvl = 0;
                    while ((len >> (lvl + 1)) != 0 && lvl + 1 < LEVELS) lvl++;
                    span  = 1 << lvl;
                    left  = level_mem[lvl][lo - 1];
                    right = level_mem[lvl][hi - span];
                    ans.minimum = (left < right) ? left : right;
                end
            end
            strmq_pkg::CMD_CLEAR: begin
                elem_count = 0;
            end
            default: begin
            end
        endcase
    endtask

    // Sends one transaction, optionally after an idle burst, and queues its answer.
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [VALUE_WIDTH-1:0] value,
                                 input logic [POS_W-1:0] pos_a,
                                 input logic [POS_W-1:0] pos_b,
                                 input bit typed,
                                 input logic signed [VALUE_WIDTH-1:0] want_min,
                                 input logic [STATUS_W-1:0] want_status);
        t_answer ans;
        if (gap_level != 0 && $urandom_range(0, 9) < gap_level) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        i_pos_a    <= pos_a;
        i_pos_b    <= pos_b;
        @(negedge i_clk);
        while (o_in_stall !== 1'b0) @(negedge i_clk);
        // The transaction is taken at the coming rising edge.
        predict_answer(cmd, value, pos_a, pos_b, ans);
        if (typed) begin
            ans.minimum = want_min;
            ans.status  = want_status;
        end
        pending_answers.push_back(ans);
        items_sent++;
        @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return VAL_MOST_NEG;
            1:       return VAL_MOST_POS;
            2:       return VALUE_WIDTH'($signed($urandom_range(0, 15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_load();
        issue_command(strmq_pkg::CMD_LOAD, pick_value(), POS_W'($urandom), POS_W'($urandom),
                      1'b0, '0, strmq_pkg::ST_OK);
    endtask

    // Query with both endpoints inside the loaded elements, in random order.
    task automatic send_query_within();
        int unsigned lo;
        int unsigned hi;
        int unsigned len;
        int unsigned max_k;
        lo = $urandom_range(1, elem_count);
        hi = lo;
        case ($urandom_range(0, 3))
            0: hi = $urandom_range(1, elem_count);
            1: begin
                max_k = 0;
                while ((2 << max_k) <= elem_count) max_k++;
                len = 1 << $urandom_range(0, max_k);
                lo  = $urandom_range(1, elem_count - len + 1);
                hi  = lo + len - 1;
            end
            2: begin
                lo = 1;
                hi = elem_count;
            end
            default: begin
            end
        endcase
        if ($urandom_range(0, 1) == 1)
            issue_command(strmq_pkg::CMD_QUERY, $urandom, POS_W'(lo), POS_W'(hi), 1'b0, '0,
                          strmq_pkg::ST_OK);
        else
            issue_command(strmq_pkg::CMD_QUERY, $urandom, POS_W'(hi), POS_W'(lo), 1'b0, '0,
                          strmq_pkg::ST_OK);
    endtask

    // Unknown commands, queries that reach outside the loaded elements, and queries with random endpoints.
    task automatic send_noise();
        int unsigned outside;
        outside = $urandom_range(elem_count + 1, 2047);
        case ($urandom_range(0, 3))
            0: issue_command(CMD_UNKNOWN, $urandom, POS_W'($urandom), POS_W'($urandom),
                             1'b0, '0, strmq_pkg::ST_OK);
            1: issue_command(strmq_pkg::CMD_QUERY, $urandom, '0,
                             POS_W'($urandom_range(0, 2047)), 1'b0, '0, strmq_pkg::ST_OK);
            2: issue_command(strmq_pkg::CMD_QUERY, $urandom, POS_W'($urandom_range(1, 2047)),
                             POS_W'(outside), 1'b0, '0, strmq_pkg::ST_OK);
            default: issue_command(strmq_pkg::CMD_QUERY, $urandom,
                                   POS_W'($urandom_range(0, 2047)),
                                   POS_W'($urandom_range(0, 2047)), 1'b0, '0,
                                   strmq_pkg::ST_OK);
        endcase
    endtask

    task automatic send_clear();
        issue_command(strmq_pkg::CMD_CLEAR, $urandom, POS_W'($urandom), POS_W'($urandom),
                      1'b0, '0, strmq_pkg::ST_OK);
    endtask

    // Receiver stalls in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_level == 0) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) < stall_level) begin
            stall_left  <= $urandom_range(0, 16);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result checker; inputs only change at rising edges, so the falling edge is stable.
    always @(negedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_answers.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending: minimum %0d status %0d",
                                        o_minimum, o_status));
            end else begin
                want = pending_answers.pop_front();
                if (o_minimum !== want.minimum)
                    note_mismatch($sformatf("minimum %0d, expected %0d",
                                            o_minimum, want.minimum));
                if (o_status !== want.status)
                    note_mismatch($sformatf("status %0d, expected %0d",
                                            o_status, want.status));
            end
        end
    end

    initial begin
        t_step step;
        int    n_loads;
        int    pick;

        // Directed rows: typed answers only where they are obvious.
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd1, 11'd1, 1'b1, '0,
                                   strmq_pkg::ST_RANGE});
        directed_steps.push_back('{strmq_pkg::CMD_LOAD, VAL_MOST_NEG, '0, '0, 1'b1, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_LOAD, VAL_MOST_POS, '0, '0, 1'b1, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_LOAD, 32'sd0, '0, '0, 1'b1, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_LOAD, -32'sd1, '0, '0, 1'b1, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_LOAD, 32'sd5, '0, '0, 1'b1, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_LOAD, 32'sd256, '0, '0, 1'b1, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_LOAD, -32'sd7, '0, '0, 1'b1, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd1, 11'd2, 1'b1, VAL_MOST_NEG,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd2, 11'd2, 1'b1, VAL_MOST_POS,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd7, 11'd3, 1'b0, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd2, 11'd7, 1'b0, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd3, 11'd6, 1'b0, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd0, 11'd4, 1'b1, '0,
                                   strmq_pkg::ST_RANGE});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd5, 11'd0, 1'b1, '0,
                                   strmq_pkg::ST_RANGE});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd8, 11'd1, 1'b1, '0,
                                   strmq_pkg::ST_RANGE});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd2047, 11'd2047, 1'b1, '0,
                                   strmq_pkg::ST_RANGE});
        directed_steps.push_back('{CMD_UNKNOWN, -32'sd1, 11'd2047, 11'd2047, 1'b1, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd1, 11'd7, 1'b0, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_CLEAR, '0, '0, '0, 1'b1, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd1, 11'd1, 1'b1, '0,
                                   strmq_pkg::ST_RANGE});
        directed_steps.push_back('{strmq_pkg::CMD_LOAD, 32'sh1234_5678, '0, '0, 1'b1, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{strmq_pkg::CMD_QUERY, '0, 11'd1, 11'd1, 1'b0, '0,
                                   strmq_pkg::ST_OK});
        directed_steps.push_back('{CMD_UNKNOWN, '0, '0, '0, 1'b1, '0, strmq_pkg::ST_OK});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_level   = 2;
        stall_level = 2;
        foreach (directed_steps[i]) begin
            step = directed_steps[i];
            issue_command(step.cmd, step.value, step.pos_a, step.pos_b,
                          step.typed, step.want_min, step.want_status);
        end

        // Random part: short build-and-query phases, one complete fill of the table.
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
                gap_level   = 0;
                stall_level = 0;
            end else begin
                gap_level   = $urandom_range(0, 4);
                stall_level = $urandom_range(0, 4);
            end
            if (!full_done && items_sent >= FULL_FILL_AFTER) begin
                full_done = 1'b1;
                send_clear();
                while (elem_count < MAX_ELEMENTS) begin
                    send_load();
                    if ($urandom_range(0, 15) == 0) send_query_within();
                end
                repeat (3) send_load();
                issue_command(strmq_pkg::CMD_QUERY, $urandom, 11'd1, POS_W'(MAX_ELEMENTS),
                              1'b0, '0, strmq_pkg::ST_OK);
                issue_command(strmq_pkg::CMD_QUERY, $urandom, POS_W'(MAX_ELEMENTS), 11'd1,
                              1'b0, '0, strmq_pkg::ST_OK);
                repeat (16) send_query_within();
                repeat (4) send_noise();
            end else begin
                if (elem_count > 160 || $urandom_range(0, 3) != 0) send_clear();
                n_loads = $urandom_range(1, 48);
                repeat (n_loads) send_load();
                repeat ($urandom_range(4, 20)) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 12 && elem_count != 0) send_query_within();
                    else if (pick < 16) send_load();
                    else send_noise();
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("sparse_table_range_minimum test passed");
        end else begin
            $display("sparse_table_range_minimum test failed");
        end
        $finish;
    end

endmodule
